// File: hdl/pas_pkg.sv
package pas_pkg;

    localparam int CordicIter    = 16;
    localparam int AngleFracBits = 8;

    // modulo: 32-bit time by 16-bit period, one quotient bit per cell
    localparam int ModSteps  = 32;
    // phase fraction: (tmod << 16) / p, one quotient bit per cell
    localparam int FracSteps = 16;

    localparam int ZW = 28;   // angle accumulator, Q.16 degrees
    localparam int VW = 36;   // vectoring x/y
    localparam int RW = 33;   // rotation x/y, signed Q2.30

    localparam logic [15:0] PivotReset  = 16'd54395;
    localparam logic [15:0] PeriodReset = 16'd1592;

    localparam logic signed [ZW-1:0] Deg90  = ZW'(90 * 65536);
    localparam logic signed [ZW-1:0] Deg180 = ZW'(180 * 65536);
    localparam logic signed [ZW-1:0] Deg270 = ZW'(270 * 65536);
    localparam logic signed [ZW-1:0] Deg360 = ZW'(360 * 65536);
    localparam logic signed [RW-1:0] InvGain = RW'(652032874);
    localparam logic signed [RW-1:0] OneQ30  = RW'(64'sd1 << 30);

    // byte addresses of the config registers
    localparam logic [2:0] AddrPivot  = 3'd0;
    localparam logic [2:0] AddrPeriod = 3'd4;

    function automatic logic signed [ZW-1:0] atan_lut(input int i);
        logic signed [ZW-1:0] v;
        unique case (i)
            0:  v = ZW'(2949120);
            1:  v = ZW'(1740967);
            2:  v = ZW'(919879);
            3:  v = ZW'(466945);
            4:  v = ZW'(234379);
            5:  v = ZW'(117304);
            6:  v = ZW'(58666);
            7:  v = ZW'(29335);
            8:  v = ZW'(14668);
            9:  v = ZW'(7334);
            10: v = ZW'(3667);
            11: v = ZW'(1833);
            12: v = ZW'(917);
            13: v = ZW'(458);
            14: v = ZW'(229);
            15: v = ZW'(115);
            16: v = ZW'(57);
            17: v = ZW'(29);
            18: v = ZW'(14);
            19: v = ZW'(7);
            20: v = ZW'(4);
            21: v = ZW'(2);
            22: v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    // payload riding the chain alongside the computation
    typedef struct packed {
        logic [15:0] len;
        logic [15:0] phase;
        logic [15:0] period;
        logic [15:0] height;
    } t_ctx;

endpackage

// File: hdl/pas_div_cell.sv
// one restoring division step: remainder shifts in one dividend bit
module pas_div_cell (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_rem,
    input  logic        i_bit,
    input  logic [15:0] i_div,
    input  logic [15:0] i_q,
    output logic [15:0] o_rem,
    output logic [15:0] o_q
);
    logic [16:0] w_t;
    logic        w_ge;
    logic [15:0] n_rem;
    logic [15:0] r_rem;
    logic [15:0] r_q;

    always_comb begin
        w_t   = {i_rem, i_bit};
        w_ge  = w_t >= {1'b0, i_div};
        n_rem = w_ge ? 16'(w_t - {1'b0, i_div}) : w_t[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_q   <= {i_q[14:0], w_ge};
        end
    end

    assign o_rem = r_rem;
    assign o_q   = r_q;
endmodule

// File: hdl/pas_vec_cell.sv
// one vectoring micro-rotation toward y = 0
module pas_vec_cell (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [4:0]                    i_sh,
    input  logic signed [pas_pkg::ZW-1:0] i_atan,
    input  logic signed [pas_pkg::VW-1:0] i_x,
    input  logic signed [pas_pkg::VW-1:0] i_y,
    input  logic signed [pas_pkg::ZW-1:0] i_z,
    output logic signed [pas_pkg::VW-1:0] o_x,
    output logic signed [pas_pkg::VW-1:0] o_y,
    output logic signed [pas_pkg::ZW-1:0] o_z
);
    logic signed [pas_pkg::VW-1:0] r_x, r_y;
    logic signed [pas_pkg::ZW-1:0] r_z;
    logic signed [pas_pkg::VW-1:0] w_dx, w_dy;

    assign w_dx = i_y >>> i_sh;
    assign w_dy = i_x >>> i_sh;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_y > 0) begin
                r_x <= i_x + w_dx;
                r_y <= i_y - w_dy;
                r_z <= i_z + i_atan;
            end else begin
                r_x <= i_x - w_dx;
                r_y <= i_y + w_dy;
                r_z <= i_z - i_atan;
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
endmodule

// File: hdl/pas_rot_cell.sv
// one rotation micro-rotation driving z to zero
module pas_rot_cell (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [4:0]                    i_sh,
    input  logic signed [pas_pkg::ZW-1:0] i_atan,
    input  logic signed [pas_pkg::RW-1:0] i_x,
    input  logic signed [pas_pkg::RW-1:0] i_y,
    input  logic signed [pas_pkg::ZW-1:0] i_z,
    output logic signed [pas_pkg::RW-1:0] o_x,
    output logic signed [pas_pkg::RW-1:0] o_y,
    output logic signed [pas_pkg::ZW-1:0] o_z
);
    logic signed [pas_pkg::RW-1:0] r_x, r_y;
    logic signed [pas_pkg::ZW-1:0] r_z;
    logic signed [pas_pkg::RW-1:0] w_dx, w_dy;

    assign w_dx = i_y >>> i_sh;
    assign w_dy = i_x >>> i_sh;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_z >= 0) begin
                r_x <= i_x - w_dx;
                r_y <= i_y + w_dy;
                r_z <= i_z - i_atan;
            end else begin
                r_x <= i_x + w_dx;
                r_y <= i_y - w_dy;
                r_z <= i_z + i_atan;
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
endmodule

// File: hdl/pendulum_angle_setpoint_unit.sv
// pipeline: 32 modulo cells + 16 fraction cells + 1 fold + 16 CORDIC cells
//   + 3 clamp/product/round stages from accept to o_valid
// throughput: one item per cycle; the chain advances whenever the output
//   register is empty or being taken, so the chain of cells sets the rate
// reset: synchronous active low; clears valid bits and restores pivot_height
//   and period_ms to their defaults
module pendulum_angle_setpoint_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_swing_length,
    input  logic [15:0] i_phase_offset,
    input  logic [31:0] i_time_ms,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [15:0] o_angle_deg,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int MS = pas_pkg::ModSteps;
    localparam int FS = pas_pkg::FracSteps;
    localparam int NI = pas_pkg::CordicIter;
    localparam int Lat = MS + FS + 1 + NI + 3;
    localparam int Sh = 46 - pas_pkg::AngleFracBits;

    logic [15:0] r_height, r_period;
    logic        w_wr;
    logic        w_adv;
    logic [Lat-1:0] r_vld;

    // config port
    assign pready = 1'b1;
    assign w_wr = psel && penable && pwrite && pready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= pas_pkg::PivotReset;
            r_period <= pas_pkg::PeriodReset;
        end else if (w_wr) begin
            if (paddr == pas_pkg::AddrPivot) begin
                r_height <= pwdata[15:0];
            end else if (paddr == pas_pkg::AddrPeriod) begin
                r_period <= pwdata[15:0];
            end
        end
    end
    always_comb begin
        prdata = '0;
        if (paddr == pas_pkg::AddrPivot) prdata = {16'd0, r_height};
        else if (paddr == pas_pkg::AddrPeriod) prdata = {16'd0, r_period};
    end

    // whole chain stalls only when output holds an untaken item
    assign w_adv   = !o_valid || i_ready;
    assign o_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (w_adv) r_vld <= {r_vld[Lat-2:0], i_valid};
    end

    // ---- modulo chain: time % p ----
    logic [15:0] w_pin;
    assign w_pin = (r_period == 16'd0) ? 16'd1 : r_period;

    logic [15:0] m_rem [MS+1];
    logic [15:0] m_q   [MS+1];
    logic [31:0] r_tsh [MS];
    pas_pkg::t_ctx r_mctx [MS];
    pas_pkg::t_ctx w_ctx0;
    assign w_ctx0 = '{len: i_swing_length, phase: i_phase_offset,
                      period: w_pin, height: r_height};
    assign m_rem[0] = '0;
    assign m_q[0]   = '0;

    for (genvar k = 0; k < MS; k++) begin : g_mod
        logic [31:0] w_t;
        pas_pkg::t_ctx w_c;
        if (k == 0) begin : g_f
            assign w_t = i_time_ms;
            assign w_c = w_ctx0;
        end else begin : g_n
            assign w_t = r_tsh[k-1];
            assign w_c = r_mctx[k-1];
        end
        pas_div_cell u_cell (
            .i_clk(i_clk), .i_en(w_adv), .i_rem(m_rem[k]), .i_bit(w_t[31]),
            .i_div(w_c.period), .i_q(m_q[k]), .o_rem(m_rem[k+1]), .o_q(m_q[k+1])
        );
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_tsh[k]  <= {w_t[30:0], 1'b0};
                r_mctx[k] <= w_c;
            end
        end
    end

    // ---- fraction chain: (tmod << 16) / p, dividend bits all zero ----
    logic [15:0] f_rem [FS+1];
    logic [15:0] f_q   [FS+1];
    pas_pkg::t_ctx r_fctx [FS];
    assign f_rem[0] = m_rem[MS];
    assign f_q[0]   = '0;

    for (genvar k = 0; k < FS; k++) begin : g_frac
        pas_pkg::t_ctx w_c;
        if (k == 0) begin : g_f
            assign w_c = r_mctx[MS-1];
        end else begin : g_n
            assign w_c = r_fctx[k-1];
        end
        pas_div_cell u_cell (
            .i_clk(i_clk), .i_en(w_adv), .i_rem(f_rem[k]), .i_bit(1'b0),
            .i_div(w_c.period), .i_q(f_q[k]), .o_rem(f_rem[k+1]), .o_q(f_q[k+1])
        );
        always_ff @(posedge i_clk) begin
            if (w_adv) r_fctx[k] <= w_c;
        end
    end

    // ---- fold stage: turn to degrees folded into [-90,90] ----
    pas_pkg::t_ctx w_fc;
    logic [15:0] w_turn;
    logic signed [pas_pkg::ZW-1:0] w_a, n_zr;
    logic signed [pas_pkg::ZW-1:0] r_zr;
    logic [15:0] r_len, r_hgt;
    assign w_fc   = r_fctx[FS-1];
    assign w_turn = 16'(f_q[FS] + w_fc.phase);
    assign w_a    = pas_pkg::ZW'({12'd0, w_turn} * 28'd360);
    always_comb begin
        if (w_a > pas_pkg::Deg90 && w_a <= pas_pkg::Deg270) n_zr = pas_pkg::Deg180 - w_a;
        else if (w_a > pas_pkg::Deg270) n_zr = w_a - pas_pkg::Deg360;
        else n_zr = w_a;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_zr  <= n_zr;
            r_len <= w_fc.len;
            r_hgt <= w_fc.height;
        end
    end

    // ---- both CORDICs as parallel rows of cells ----
    logic signed [pas_pkg::VW-1:0] v_x [NI+1];
    logic signed [pas_pkg::VW-1:0] v_y [NI+1];
    logic signed [pas_pkg::ZW-1:0] v_z [NI+1];
    logic signed [pas_pkg::RW-1:0] q_x [NI+1];
    logic signed [pas_pkg::RW-1:0] q_y [NI+1];
    logic signed [pas_pkg::ZW-1:0] q_z [NI+1];
    logic [NI-1:0] r_lz;

    assign v_x[0] = pas_pkg::VW'({r_hgt, 16'd0});
    assign v_y[0] = pas_pkg::VW'({r_len, 16'd0});
    assign v_z[0] = '0;
    assign q_x[0] = pas_pkg::InvGain;
    assign q_y[0] = '0;
    assign q_z[0] = r_zr;

    for (genvar k = 0; k < NI; k++) begin : g_cordic
        pas_vec_cell u_vec (
            .i_clk(i_clk), .i_en(w_adv), .i_sh(5'(k)), .i_atan(pas_pkg::atan_lut(k)),
            .i_x(v_x[k]), .i_y(v_y[k]), .i_z(v_z[k]),
            .o_x(v_x[k+1]), .o_y(v_y[k+1]), .o_z(v_z[k+1])
        );
        pas_rot_cell u_rot (
            .i_clk(i_clk), .i_en(w_adv), .i_sh(5'(k)), .i_atan(pas_pkg::atan_lut(k)),
            .i_x(q_x[k]), .i_y(q_y[k]), .i_z(q_z[k]),
            .o_x(q_x[k+1]), .o_y(q_y[k+1]), .o_z(q_z[k+1])
        );
    end

    // zero-length flag travels along the cordic row
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (NI > 1) r_lz <= {r_lz[NI-2:0], (r_len == 16'd0)};
            else r_lz[0] <= (r_len == 16'd0);
        end
    end

    // ---- clamp, multiply, round ----
    logic signed [pas_pkg::ZW-1:0] w_amp;
    logic signed [pas_pkg::RW-1:0] w_sin;
    logic signed [pas_pkg::ZW-1:0] r_amp;
    logic signed [pas_pkg::RW-1:0] r_sin;
    always_comb begin
        w_amp = v_z[NI];
        if (r_lz[NI-1] || w_amp < 0) w_amp = '0;
        else if (w_amp > pas_pkg::Deg90) w_amp = pas_pkg::Deg90;
        w_sin = q_y[NI];
        if (w_sin > pas_pkg::OneQ30) w_sin = pas_pkg::OneQ30;
        else if (w_sin < -pas_pkg::OneQ30) w_sin = -pas_pkg::OneQ30;
    end

    logic signed [63:0] r_prod;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_amp  <= w_amp;
            r_sin  <= w_sin;
            r_prod <= 64'(r_amp) * 64'(r_sin);
        end
    end

    logic signed [63:0] w_rnd;
    logic signed [63:0] w_lim;
    logic signed [15:0] n_out;
    logic signed [15:0] r_out;
    assign w_rnd = (r_prod + (64'sd1 <<< (Sh - 1))) >>> Sh;
    assign w_lim = 64'sd90 <<< pas_pkg::AngleFracBits;
    always_comb begin
        logic signed [63:0] v;
        v = w_rnd;
        if (v > w_lim) v = w_lim;
        if (v < -w_lim) v = -w_lim;
        if (v > 64'sd32767) v = 64'sd32767;
        if (v < -64'sd32768) v = -64'sd32768;
        n_out = 16'(v);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) r_out <= n_out;
    end

    assign o_valid     = r_vld[Lat-1];
    assign o_angle_deg = r_out;

    // ---- checks ----
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_angle_deg))
        else $error("output item changed while stalled");
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("not ready with empty output");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_angle_deg <= 16'sd23040 && o_angle_deg >= -16'sd23040))
        else $error("angle out of range");
endmodule
